@@ rtl/core/sftb_pkg.sv @@
// sftb_pkg: shared types, constants and helpers for the spi flash / touch bus block
// no dependencies; imported by the input, execute and output stages, the top level and the bench
`default_nettype none

package sftb_pkg;

  // flash array size and address width
  localparam int FLASH_BYTES = 131072;
  localparam int FLASH_AW    = $clog2(FLASH_BYTES);

  // item command codes
  typedef enum logic [2:0] {
    CMD_CTRL  = 3'd0,
    CMD_DATA  = 3'd1,
    CMD_LOAD  = 3'd2,
    CMD_TOUCH = 3'd3,
    CMD_MIC   = 3'd4
  } cmd_t;

  // control register layout
  localparam logic [15:0] CTRL_WR_MASK  = 16'hCF03;
  localparam int          CTRL_EN_BIT   = 15;
  localparam int          CTRL_IRQ_BIT  = 14;
  localparam int          CTRL_HOLD_BIT = 11;
  localparam int          CTRL_WIDE_BIT = 10;
  localparam int          CTRL_DEV_LSB  = 8;

  // device select codes
  localparam logic [1:0] DEV_FLASH = 2'd1;
  localparam logic [1:0] DEV_TOUCH = 2'd2;

  // flash read opcode and length of the address phase
  localparam logic [7:0]  FLASH_RD_OP    = 8'h03;
  localparam logic [15:0] ADDR_PHASE_END = 16'd4;

  // touch channel codes, command bits 6..4
  localparam logic [2:0] CH_Y   = 3'd1;
  localparam logic [2:0] CH_X   = 3'd5;
  localparam logic [2:0] CH_MIC = 3'd6;

  localparam logic [11:0] TOUCH_Y_IDLE = 12'hFFF;

  // how the returned byte is formed after the flash read
  typedef enum logic [1:0] {
    SEL_BYTE  = 2'd0,
    SEL_RAM   = 2'd1,
    SEL_LATCH = 2'd2
  } sel_t;

  // one input item as held in the input register
  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] write_mask;
    logic [15:0] write_value;
    logic [16:0] load_address;
    logic [7:0]  load_byte;
    logic [11:0] touch_x_in;
    logic [11:0] touch_y_in;
    logic [11:0] mic_in;
  } item_t;

  // result in flight between execute and output stage
  typedef struct packed {
    sel_t       sel;
    logic [7:0] data;
    logic       irq;
  } mid_t;

  // flash memory access request
  typedef struct packed {
    logic                en;
    logic                we;
    logic [FLASH_AW-1:0] addr;
    logic [7:0]          wdata;
  } ram_req_t;

  // adc level split over two bus bytes
  function automatic logic [7:0] adc_byte(input logic [11:0] level, input logic odd);
    logic [7:0] res;
    if (odd) res = {1'b0, level[11:5]};
    else     res = {level[4:0], 3'b000};
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sftb_if.sv @@
// sftb_in_if / sftb_out_if: valid-ready channels for items and results
// depends on nothing; used by the top level and its stages
`default_nettype none

interface sftb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] write_mask;
  logic [15:0] write_value;
  logic [16:0] load_address;
  logic [7:0]  load_byte;
  logic [11:0] touch_x_in;
  logic [11:0] touch_y_in;
  logic [11:0] mic_in;

  modport source (output valid, cmd, write_mask, write_value, load_address, load_byte,
                  touch_x_in, touch_y_in, mic_in, input ready);
  modport sink   (input valid, cmd, write_mask, write_value, load_address, load_byte,
                  touch_x_in, touch_y_in, mic_in, output ready);
endinterface

interface sftb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq;

  modport source (output valid, read_data, irq, input ready);
  modport sink   (input valid, read_data, irq, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sftb_ram.sv @@
// sftb_ram: generic single-port ram with registered read
// no dependencies; holds the flash contents
`default_nettype none

module sftb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write or read one entry per enabled cycle; read data held otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      else    rdata_r   <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/core/sftb_in_stage.sv @@
// sftb_in_stage: input register of the item channel
// depends on sftb_pkg and sftb_in_if
`default_nettype none

module sftb_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  sftb_in_if.sink             in_bus,
  input  wire logic           adv,
  output logic                item_valid,
  output sftb_pkg::item_t     item
);
  import sftb_pkg::*;

  logic  valid_r;
  item_t item_r;
  logic  load;

  // room when empty or when the held item moves on this cycle
  assign in_bus.ready = !valid_r || adv;
  assign load         = in_bus.valid && in_bus.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      valid_r <= in_bus.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{cmd:          in_bus.cmd,
                  write_mask:   in_bus.write_mask,
                  write_value:  in_bus.write_value,
                  load_address: in_bus.load_address,
                  load_byte:    in_bus.load_byte,
                  touch_x_in:   in_bus.touch_x_in,
                  touch_y_in:   in_bus.touch_y_in,
                  mic_in:       in_bus.mic_in};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

@@ rtl/core/sftb_exec.sv @@
// sftb_exec: bus state, command decode and flash access for one item per cycle
// when adv is high; depends on sftb_pkg; drives flash ram and output stage
`default_nettype none

module sftb_exec (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire sftb_pkg::item_t   item,
  input  wire logic              adv,
  output sftb_pkg::ram_req_t     ram_req,
  output logic                   mid_valid,
  output sftb_pkg::mid_t         mid
);
  import sftb_pkg::*;

  logic [15:0] ctrl_r,      ctrl_nxt;
  logic [15:0] count_r,     count_nxt;
  logic [7:0]  cmd_latch_r, cmd_latch_nxt;
  logic [31:0] ptr_r,       ptr_nxt;
  logic [11:0] tx_r,        tx_nxt;
  logic [11:0] ty_r,        ty_nxt;
  logic [11:0] mic_r,       mic_nxt;
  logic        mid_valid_r, mid_valid_nxt;
  mid_t        mid_r,       mid_nxt;

  logic        fire;
  logic [15:0] wmask;
  logic [7:0]  v;
  logic [31:0] load_addr32;
  logic [31:0] step;
  logic [2:0]  ch;
  logic [1:0]  dev;

  assign fire        = item_valid && adv;
  assign wmask       = item.write_mask & CTRL_WR_MASK;
  assign v           = item.write_value[7:0];
  assign load_addr32 = 32'(item.load_address);
  assign step        = ctrl_r[CTRL_WIDE_BIT] ? 32'd2 : 32'd1;
  assign ch          = cmd_latch_r[6:4];
  assign dev         = ctrl_r[CTRL_DEV_LSB+1:CTRL_DEV_LSB];

  // decode one item and work out the next state
  always_comb begin
    ctrl_nxt      = ctrl_r;
    count_nxt     = count_r;
    cmd_latch_nxt = cmd_latch_r;
    ptr_nxt       = ptr_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    mic_nxt       = mic_r;
    mid_valid_nxt = 1'b0;
    mid_nxt       = '{sel: SEL_BYTE, data: 8'h00, irq: 1'b0};
    ram_req       = '{en: 1'b0, we: 1'b0, addr: ptr_r[FLASH_AW-1:0], wdata: item.load_byte};

    if (fire) begin
      case (cmd_t'(item.cmd))
        CMD_CTRL: begin
          ctrl_nxt = (ctrl_r & ~wmask) | (item.write_value & wmask);
        end
        CMD_DATA: begin
          mid_valid_nxt = 1'b1;
          if (ctrl_r[CTRL_EN_BIT]) begin
            mid_nxt.irq = ctrl_r[CTRL_IRQ_BIT];
            if (count_r == 16'd0) begin
              // first byte of a transfer carries the device command
              cmd_latch_nxt = v;
              ptr_nxt       = 32'd0;
            end else if (dev == DEV_FLASH) begin
              if (cmd_latch_r == FLASH_RD_OP) begin
                if (count_r < ADDR_PHASE_END) begin
                  // address phase: most significant byte first
                  mid_nxt.sel = SEL_LATCH;
                  case (count_r[1:0])
                    2'd1:    ptr_nxt = ptr_r | {8'h00, v, 16'h0000};
                    2'd2:    ptr_nxt = ptr_r | {16'h0000, v, 8'h00};
                    default: ptr_nxt = ptr_r | {24'h000000, v};
                  endcase
                end else begin
                  // data phase: read at the pointer, zero past the array
                  if (ptr_r < 32'(FLASH_BYTES)) begin
                    mid_nxt.sel = SEL_RAM;
                    ram_req.en  = 1'b1;
                  end
                  ptr_nxt = ptr_r + step;
                end
              end
            end else if (dev == DEV_TOUCH) begin
              case (ch)
                CH_Y:    mid_nxt.data = adc_byte(ty_r, count_r[0]);
                CH_X:    mid_nxt.data = adc_byte(tx_r, count_r[0]);
                CH_MIC:  mid_nxt.data = adc_byte(mic_r, count_r[0]);
                default: mid_nxt.data = 8'h00;
              endcase
            end
            count_nxt = ctrl_r[CTRL_HOLD_BIT] ? count_r + 16'd1 : 16'd0;
          end
        end
        CMD_LOAD: begin
          if (load_addr32 < 32'(FLASH_BYTES)) begin
            ram_req.en   = 1'b1;
            ram_req.we   = 1'b1;
            ram_req.addr = load_addr32[FLASH_AW-1:0];
          end
        end
        CMD_TOUCH: begin
          tx_nxt = item.touch_x_in;
          ty_nxt = item.touch_y_in;
        end
        CMD_MIC: begin
          mic_nxt = item.mic_in;
        end
        default: begin
          ctrl_nxt = ctrl_r;
        end
      endcase
    end
  end

  // bus state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= 16'h0000;
      count_r     <= 16'h0000;
      cmd_latch_r <= 8'h00;
      ptr_r       <= 32'd0;
      tx_r        <= 12'h000;
      ty_r        <= TOUCH_Y_IDLE;
      mic_r       <= 12'h000;
      mid_valid_r <= 1'b0;
    end else begin
      ctrl_r      <= ctrl_nxt;
      count_r     <= count_nxt;
      cmd_latch_r <= cmd_latch_nxt;
      ptr_r       <= ptr_nxt;
      tx_r        <= tx_nxt;
      ty_r        <= ty_nxt;
      mic_r       <= mic_nxt;
      if (adv) mid_valid_r <= mid_valid_nxt;
    end
  end

  // result waiting for the flash read data
  always_ff @(posedge clk) begin
    if (adv) mid_r <= mid_nxt;
  end

  assign mid_valid = mid_valid_r;
  assign mid       = mid_r;

endmodule

`default_nettype wire

@@ rtl/core/sftb_out_stage.sv @@
// sftb_out_stage: merges flash read data into the result and holds the output register
// depends on sftb_pkg and sftb_out_if
`default_nettype none

module sftb_out_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            mid_valid,
  input  wire sftb_pkg::mid_t  mid,
  input  wire logic [7:0]      ram_rdata,
  sftb_out_if.source           out_bus,
  output logic                 adv
);
  import sftb_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;
  logic       irq_r;
  logic [7:0] latch_r, latch_nxt;

  // pipeline moves whenever the output register is free or being taken
  assign adv = !valid_r || out_bus.ready;

  // returned byte
  always_comb begin
    case (mid.sel)
      SEL_RAM:   latch_nxt = ram_rdata;
      SEL_LATCH: latch_nxt = latch_r;
      default:   latch_nxt = mid.data;
    endcase
  end

  // valid flag and last returned byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      latch_r <= 8'h00;
    end else if (adv) begin
      valid_r <= mid_valid;
      if (mid_valid) latch_r <= latch_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv && mid_valid) begin
      data_r <= latch_nxt;
      irq_r  <= mid.irq;
    end
  end

  assign out_bus.valid     = valid_r;
  assign out_bus.read_data = data_r;
  assign out_bus.irq       = irq_r;

endmodule

`default_nettype wire

@@ rtl/core/spi_flash_touch_bus.sv @@
// spi_flash_touch_bus: spi bus master model with a serial flash and a touch adc
// depends on sftb_pkg, sftb_if, sftb_in_stage, sftb_exec, sftb_ram, sftb_out_stage
//
// Usage
//   in_bus carries one item per handshake (valid and ready high at a rising edge):
//   control writes, data bytes, flash preloads and touch / mic level updates.
//   out_bus returns one item (read_data, irq) for every data byte, in order;
//   all other commands return nothing.
// Pipeline
//   an accepted item passes the input register, the execute stage with the flash
//   ram read, and the output register before its result appears on out_bus.
//   One item per cycle is sustained while out_bus takes results; the flash ram's
//   single port does one load or one read per item.
// Reset
//   rst_n is synchronous, active low; control, count, command, pointer and
//   levels clear (touch Y to no touch). Flash contents are not cleared and
//   read as undefined until loaded.
// Stalls
//   while out_bus.ready is low with a result held, the pipeline freezes; an
//   empty input register still takes one more item, then in_bus.ready drops.
`default_nettype none

module spi_flash_touch_bus (
  input  wire logic clk,
  input  wire logic rst_n,
  sftb_in_if.sink   in_bus,
  sftb_out_if.source out_bus
);
  import sftb_pkg::*;

  logic     adv;
  logic     item_valid;
  item_t    item;
  ram_req_t ram_req;
  logic     mid_valid;
  mid_t     mid;
  logic [7:0] ram_rdata;

  sftb_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  sftb_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .adv        (adv),
    .ram_req    (ram_req),
    .mid_valid  (mid_valid),
    .mid        (mid)
  );

  sftb_ram #(
    .WIDTH (8),
    .DEPTH (FLASH_BYTES)
  ) u_flash (
    .clk   (clk),
    .en    (ram_req.en),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  sftb_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid       (mid),
    .ram_rdata (ram_rdata),
    .out_bus   (out_bus),
    .adv       (adv)
  );

endmodule

`default_nettype wire

@@ rtl/core/sftb_checker.sv @@
// sftb_checker: port-level assertions for spi_flash_touch_bus, bound to the top level
// depends on nothing but the top level's ports
`default_nettype none

module sftb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_read_data,
  input wire logic       out_irq
);

  // a held result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_data) && $stable(out_irq))
    else $error("result payload changed while stalled");

  // the input side only backs up behind a stalled result
  a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind spi_flash_touch_bus sftb_checker u_sftb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_read_data (out_bus.read_data),
  .out_irq       (out_bus.irq)
);

`default_nettype wire

@@ sim/tb_spi_flash_touch_bus.sv @@
// tb_spi_flash_touch_bus: self-checking bench for the spi flash / touch bus block
// depends on sftb_pkg, sftb_if and spi_flash_touch_bus; every data item is checked
// against a bench-side model of the control, transfer, flash and adc state
module tb_spi_flash_touch_bus;
  import sftb_pkg::*;

  // control register fields as 16-bit masks
  localparam logic [15:0] BUS_EN          = 16'h1 << CTRL_EN_BIT;
  localparam logic [15:0] IRQ_EN          = 16'h1 << CTRL_IRQ_BIT;
  localparam logic [15:0] CS_HOLD         = 16'h1 << CTRL_HOLD_BIT;
  localparam logic [15:0] WIDE            = 16'h1 << CTRL_WIDE_BIT;
  localparam logic [15:0] SPARE_BITS      = 16'h0003;
  localparam logic [15:0] DEV_SEL_FLASH   = 16'(DEV_FLASH) << CTRL_DEV_LSB;
  localparam logic [15:0] DEV_SEL_TOUCH   = 16'(DEV_TOUCH) << CTRL_DEV_LSB;
  localparam logic [15:0] DEV_SEL_UNKNOWN = 16'h3 << CTRL_DEV_LSB;

  // command codes the block ignores, a flash opcode it does not serve, a dead channel
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
  localparam logic [7:0] FLASH_FAST_OP = 8'h0B;
  localparam logic [2:0] CH_NONE       = 3'd7;

  typedef struct packed {
    logic [15:0] ctrl;
    logic [15:0] count;
    logic [7:0]  op;
    logic [31:0] ptr;
    logic [7:0]  latch;
    logic [11:0] x_lvl;
    logic [11:0] y_lvl;
    logic [11:0] mic_lvl;
  } bus_state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } reply_t;

  typedef struct {
    item_t it;
    int    gap;
    bit    no_gaps;
  } stim_t;

  typedef struct {
    reply_t rep;
    int     tag;
  } due_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  item_t cur = '0;
  logic  drv_valid = 1'b0;
  logic  sink_ready = 1'b1;
  logic  quiet_sink = 1'b0;
  int    cycle_no = 0;
  int    mismatches = 0;

  // bench state: planning copy used while building stimulus, checking copy on acceptance
  bus_state_t plan;
  bus_state_t chk;
  bit         flash_set [FLASH_BYTES];
  logic [7:0] flash_img [FLASH_BYTES];
  stim_t      stim_q [$];
  stim_t      staged;
  bit         have_staged = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  bit         burst = 1'b0;
  due_t       due_replies [$];

  sftb_in_if  in_bus ();
  sftb_out_if out_bus ();

  assign in_bus.valid = drv_valid;
  assign {in_bus.cmd, in_bus.write_mask, in_bus.write_value, in_bus.load_address,
          in_bus.load_byte, in_bus.touch_x_in, in_bus.touch_y_in, in_bus.mic_in} = cur;
  assign out_bus.ready = sink_ready;

  spi_flash_touch_bus dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_no <= cycle_no + 1;

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bus_state_t bus_reset_state();
    bus_state_t s;
    s = '0;
    s.y_lvl = TOUCH_Y_IDLE;
    return s;
  endfunction

  // one item through the bus model; mem_byte is the flash byte at the current pointer
  function automatic bit spi_bus_step(inout bus_state_t s, input item_t it,
                                      input logic [7:0] mem_byte, output reply_t rep);
    logic [15:0] lane;
    logic [7:0]  v;
    logic [7:0]  nb;
    logic [1:0]  dev;
    logic [11:0] lvl;
    bit          hit;
    bit          has_reply;
    int          sh;
    rep = '0;
    has_reply = 1'b0;
    lvl = '0;
    case (it.cmd)
      CMD_CTRL: begin
        lane = it.write_mask & CTRL_WR_MASK;
        s.ctrl = (s.ctrl & ~lane) | (it.write_value & lane);
      end
      CMD_DATA: begin
        has_reply = 1'b1;
        v = it.write_value[7:0];
        if (!s.ctrl[CTRL_EN_BIT]) begin
          s.latch = 8'h00;
        end else begin
          dev = s.ctrl[CTRL_DEV_LSB +: 2];
          if (s.count == 16'd0) begin
            // first byte of a transfer is the command
            s.op = v;
            s.ptr = '0;
            s.latch = 8'h00;
          end else begin
            nb = 8'h00;
            if (dev == DEV_FLASH) begin
              if (s.op == FLASH_RD_OP) begin
                if (s.count < ADDR_PHASE_END) begin
                  sh = (3 - int'(s.count)) * 8;
                  s.ptr = s.ptr | (32'(v) << sh);
                  nb = s.latch;
                end else begin
                  nb = (s.ptr < FLASH_BYTES) ? mem_byte : 8'h00;
                  s.ptr = s.ptr + (s.ctrl[CTRL_WIDE_BIT] ? 32'd2 : 32'd1);
                end
              end
            end else if (dev == DEV_TOUCH) begin
              hit = 1'b1;
              case (s.op[6:4])
                CH_Y:    lvl = s.y_lvl;
                CH_X:    lvl = s.x_lvl;
                CH_MIC:  lvl = s.mic_lvl;
                default: hit = 1'b0;
              endcase
              if (hit) nb = s.count[0] ? {1'b0, lvl[11:5]} : {lvl[4:0], 3'b000};
            end
            s.latch = nb;
          end
          s.count = s.ctrl[CTRL_HOLD_BIT] ? s.count + 16'd1 : 16'd0;
          rep.irq = s.ctrl[CTRL_IRQ_BIT];
        end
        rep.read_data = s.latch;
      end
      CMD_TOUCH: begin
        s.x_lvl = it.touch_x_in;
        s.y_lvl = it.touch_y_in;
      end
      CMD_MIC: s.mic_lvl = it.mic_in;
      default: ;
    endcase
    return has_reply;
  endfunction

  function automatic item_t rnd_item(logic [2:0] c);
    item_t it;
    it = item_t'({$urandom, $urandom, $urandom});
    it.cmd = c;
    return it;
  endfunction

  // append an item, preloading any flash byte the stream is about to read unloaded
  task automatic queue_item(item_t it);
    stim_t  e;
    reply_t unused;
    if (it.cmd == CMD_DATA && plan.ctrl[CTRL_EN_BIT] && plan.count >= ADDR_PHASE_END &&
        plan.ctrl[CTRL_DEV_LSB +: 2] == DEV_FLASH && plan.op == FLASH_RD_OP &&
        plan.ptr < FLASH_BYTES && !flash_set[plan.ptr[FLASH_AW-1:0]])
      put_load(plan.ptr[FLASH_AW-1:0], 8'($urandom));
    if (it.cmd == CMD_LOAD && it.load_address < FLASH_BYTES)
      flash_set[it.load_address] = 1'b1;
    void'(spi_bus_step(plan, it, 8'h00, unused));
    e.it = it;
    e.gap = burst ? 0 : $urandom_range(0, 12);
    e.no_gaps = burst;
    stim_q.push_back(e);
  endtask

  task automatic put_load(logic [16:0] addr, logic [7:0] b);
    item_t it;
    it = rnd_item(CMD_LOAD);
    it.load_address = addr;
    it.load_byte = b;
    queue_item(it);
  endtask

  task automatic put_ctrl(logic [15:0] value, logic [15:0] mask);
    item_t it;
    it = rnd_item(CMD_CTRL);
    it.write_value = value;
    it.write_mask = mask;
    queue_item(it);
  endtask

  task automatic put_byte(logic [7:0] v);
    item_t it;
    it = rnd_item(CMD_DATA);
    it.write_value[7:0] = v;
    queue_item(it);
  endtask

  // end any open transfer, then open a new one with hold set and send the command byte
  task automatic start_transfer(logic [15:0] mode, logic [7:0] op);
    logic [15:0] m;
    m = mode | BUS_EN | CS_HOLD;
    if (plan.count != 16'd0) begin
      put_ctrl((m & ~CS_HOLD & CTRL_WR_MASK) | (16'($urandom) & ~CTRL_WR_MASK),
               16'($urandom) | CTRL_WR_MASK);
      put_byte(8'($urandom));
    end
    put_ctrl((m & CTRL_WR_MASK) | (16'($urandom) & ~CTRL_WR_MASK), 16'($urandom) | CTRL_WR_MASK);
    put_byte(op);
  endtask

  // driver: presents queued items and predicts each accepted one
  always @(posedge clk) begin
    reply_t     rep;
    logic [7:0] mem_byte;
    bit         free;
    if (!rst_n) begin
      drv_valid <= 1'b0;
      have_staged = 1'b0;
      gap_left = 0;
      chk = bus_reset_state();
    end else begin
      free = !drv_valid;
      if (drv_valid && in_bus.ready) begin
        free = 1'b1;
        mem_byte = (chk.ptr < FLASH_BYTES) ? flash_img[chk.ptr[FLASH_AW-1:0]] : 8'h00;
        if (cur.cmd == CMD_LOAD && cur.load_address < FLASH_BYTES)
          flash_img[cur.load_address] = cur.load_byte;
        if (spi_bus_step(chk, cur, mem_byte, rep))
          due_replies.push_back('{rep, cycle_no});
      end
      if (free) begin
        if (!have_staged && stim_q.size() != 0) begin
          staged = stim_q.pop_front();
          have_staged = 1'b1;
          gap_left = staged.gap;
        end
        if (have_staged && gap_left == 0) begin
          cur <= staged.it;
          drv_valid <= 1'b1;
          quiet_sink <= staged.no_gaps;
          have_staged = 1'b0;
        end else begin
          drv_valid <= 1'b0;
          if (have_staged) gap_left--;
        end
      end
    end
  end

  // monitor: random back-pressure and field checks against the oldest prediction
  always @(posedge clk) begin
    due_t d;
    if (!rst_n) begin
      sink_ready <= 1'b1;
      stall_left = 0;
    end else if (out_bus.valid && sink_ready) begin
      if (due_replies.size() == 0 || due_replies[0].tag >= cycle_no) begin
        mismatches++;
        $error("result with no item pending: read_data %02h irq %0b",
               out_bus.read_data, out_bus.irq);
      end else begin
        d = due_replies.pop_front();
        if (out_bus.read_data !== d.rep.read_data) begin
          mismatches++;
          $error("read_data: expected %02h, got %02h", d.rep.read_data, out_bus.read_data);
        end
        if (out_bus.irq !== d.rep.irq) begin
          mismatches++;
          $error("irq: expected %0b, got %0b", d.rep.irq, out_bus.irq);
        end
      end
      stall_left = quiet_sink ? 0 : $urandom_range(0, 12);
      sink_ready <= (stall_left == 0);
    end else if (!sink_ready) begin
      stall_left--;
      if (stall_left <= 0) sink_ready <= 1'b1;
    end
  end

  // stimulus, then wait for the tail
  initial begin
    item_t       it;
    logic [23:0] base;
    logic [7:0]  op;
    logic [2:0]  ch;
    logic [2:0]  c;
    int          pick;
    int          start_n;
    plan = bus_reset_state();

    // bus disabled after reset
    put_byte(8'hFF);
    // every writable bit set: unknown device
    put_ctrl(16'hFFFF, 16'hFFFF);
    put_byte(FLASH_RD_OP);
    put_byte(8'h00);
    // partial lane write drops enable; count must hold
    put_ctrl(16'h0000, 16'hF0FF);
    put_byte(8'hAA);

    // touch Y reads its no-touch level before any update
    start_transfer(IRQ_EN | DEV_SEL_TOUCH, {1'b0, CH_Y, 4'h0});
    put_byte(8'h00);
    put_byte(8'hFF);
    it = rnd_item(CMD_TOUCH);
    it.touch_x_in = 12'hFFF;
    it.touch_y_in = 12'h000;
    queue_item(it);
    it = rnd_item(CMD_MIC);
    it.mic_in = 12'h800;
    queue_item(it);
    start_transfer(DEV_SEL_TOUCH, {1'b1, CH_X, 4'h0});
    put_byte(8'h00);
    put_byte(8'h00);
    start_transfer(DEV_SEL_TOUCH, {1'b0, CH_MIC, 4'h0});
    put_byte(8'h00);
    put_byte(8'h00);
    start_transfer(DEV_SEL_TOUCH, {1'b0, CH_NONE, 4'h0});
    put_byte(8'h00);

    // flash read running off the end of the array
    put_load(17'h1FFFE, 8'hA5);
    put_load(17'h1FFFF, 8'h5A);
    start_transfer(IRQ_EN | DEV_SEL_FLASH, FLASH_RD_OP);
    put_byte(8'h01);
    put_byte(8'hFF);
    put_byte(8'hFE);
    repeat (4) put_byte(8'h00);
    // 16-bit mode steps the address by two
    put_load(17'h00000, 8'hFF);
    put_load(17'h00002, 8'h81);
    start_transfer(WIDE | DEV_SEL_FLASH, FLASH_RD_OP);
    repeat (5) put_byte(8'h00);
    // flash opcode other than read
    start_transfer(DEV_SEL_FLASH, FLASH_FAST_OP);
    put_byte(8'h12);
    put_byte(8'h34);
    // hold clear: every byte starts a new transfer
    put_ctrl(BUS_EN | DEV_SEL_TOUCH, 16'hFFFF);
    put_byte({1'b0, CH_Y, 4'h0});
    put_byte({1'b0, CH_Y, 4'h0});
    queue_item(rnd_item(CMD_SPARE_LO));
    queue_item(rnd_item(CMD_SPARE_HI));

    // random sequences: flash reads, touch reads, noise
    start_n = stim_q.size();
    while (stim_q.size() - start_n < 1200) begin
      burst = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        case ($urandom_range(0, 9))
          8:       base = 24'(FLASH_BYTES - $urandom_range(1, 8));
          9:       base = 24'($urandom);
          default: base = 24'($urandom_range(0, FLASH_BYTES - 1));
        endcase
        op = ($urandom_range(0, 7) == 0) ? 8'($urandom) : FLASH_RD_OP;
        if ($urandom_range(0, 1))
          for (int k = 0; k < 4; k++)
            if (base + k < FLASH_BYTES) put_load(17'(base + k), 8'($urandom));
        start_transfer(DEV_SEL_FLASH | (16'($urandom) & (IRQ_EN | WIDE | SPARE_BITS)), op);
        put_byte(base[23:16]);
        put_byte(base[15:8]);
        put_byte(base[7:0]);
        repeat ($urandom_range(1, 8)) put_byte(8'($urandom));
      end else if (pick <= 6) begin
        if ($urandom_range(0, 1)) queue_item(rnd_item(CMD_TOUCH));
        if ($urandom_range(0, 1)) queue_item(rnd_item(CMD_MIC));
        case ($urandom_range(0, 3))
          0:       ch = CH_Y;
          1:       ch = CH_X;
          2:       ch = CH_MIC;
          default: ch = 3'($urandom);
        endcase
        op = 8'($urandom);
        op[6:4] = ch;
        start_transfer(DEV_SEL_TOUCH | (16'($urandom) & (IRQ_EN | WIDE | SPARE_BITS)), op);
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          c = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'(CMD_DATA);
          queue_item(rnd_item(c));
        end
        if ($urandom_range(0, 3) == 0)
          put_ctrl(DEV_SEL_UNKNOWN | BUS_EN | 16'($urandom), 16'($urandom));
      end
    end
    burst = 1'b0;

    // drain: all items sent and every result back
    @(negedge clk);
    while (stim_q.size() != 0 || have_staged || drv_valid || due_replies.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/sftb_pkg.sv
rtl/core/sftb_if.sv
rtl/core/sftb_ram.sv
rtl/core/sftb_in_stage.sv
rtl/core/sftb_exec.sv
rtl/core/sftb_out_stage.sv
rtl/core/spi_flash_touch_bus.sv
rtl/core/sftb_checker.sv
sim/tb_spi_flash_touch_bus.sv
